// ----- rtl/mss_pkg.sv -----
package mss_pkg;

   // Display geometry and input range.
   localparam int unsigned MAX_DIGITS = 4;
   localparam int unsigned VALUE_W    = 14;
   localparam int unsigned TIME_W     = 32;
   localparam int unsigned BCD_W      = 16;
   localparam int unsigned SEG_W      = 8;
   localparam int unsigned IDX_W      = 2;
   localparam int unsigned CNT_W      = 3;
   localparam int unsigned BASE_W     = 8;
   localparam logic [VALUE_W-1:0] VALUE_MAX = 14'd9999;

   // Double dabble takes one step per input bit.
   localparam int unsigned BCD_STEPS  = VALUE_W;
   localparam int unsigned STEP_W     = $clog2(BCD_STEPS);

   // Configuration port.
   localparam int unsigned ADDR_W     = 4;
   localparam int unsigned DATA_W     = 32;

   localparam logic [CNT_W-1:0]  DIGIT_COUNT_RST  = 3'd4;
   localparam logic              COMMON_ANODE_RST = 1'b0;
   localparam logic [BASE_W-1:0] SCAN_BASE_RST    = 8'd10;

   typedef enum logic [1:0] {
      REG_DIGIT_COUNT  = 2'd0,
      REG_COMMON_ANODE = 2'd1,
      REG_SCAN_BASE    = 2'd2,
      REG_UNUSED       = 2'd3
   } reg_index_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CHECK,
      ST_CONV,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic [CNT_W-1:0]  digit_count;
      logic              common_anode;
      logic [BASE_W-1:0] scan_base_ms;
   } cfg_type;

   // Digit count clamped into 1..MAX_DIGITS.
   function automatic logic [CNT_W-1:0] eff_count(input logic [CNT_W-1:0] raw);
      logic [CNT_W-1:0] c;
      c = raw;
      if (c == '0) begin
         c = CNT_W'(1);
      end
      if (c > CNT_W'(MAX_DIGITS)) begin
         c = CNT_W'(MAX_DIGITS);
      end
      return c;
   endfunction

   // Segment pattern of one decimal digit, bit0 is segment a, bit7 the point.
   function automatic logic [SEG_W-1:0] seg_pattern(input logic [3:0] digit);
      logic [SEG_W-1:0] p;
      case (digit)
         4'd0:    p = 8'h3F;
         4'd1:    p = 8'h06;
         4'd2:    p = 8'h5B;
         4'd3:    p = 8'h4F;
         4'd4:    p = 8'h66;
         4'd5:    p = 8'h6D;
         4'd6:    p = 8'h7D;
         4'd7:    p = 8'h07;
         4'd8:    p = 8'h7F;
         4'd9:    p = 8'h67;
         default: p = 8'h00;
      endcase
      return p;
   endfunction

endpackage

// ----- rtl/mss_csr.sv -----
module mss_csr (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_psel,
   input  logic                         csr_penable,
   input  logic                         csr_pwrite,
   input  logic [mss_pkg::ADDR_W-1:0]   csr_paddr,
   input  logic [mss_pkg::DATA_W-1:0]   csr_pwdata,
   output logic [mss_pkg::DATA_W-1:0]   csr_prdata,
   output logic                         csr_pready,
   output mss_pkg::cfg_type             cfg
);
   import mss_pkg::*;

   cfg_type       cfg_ff, cfg_in;
   reg_index_type sel;
   logic          wr_en;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel & csr_penable & csr_pwrite;
   assign sel        = reg_index_type'(csr_paddr[ADDR_W-1:2]);
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in     = cfg_ff;
      csr_prdata = '0;
      unique case (sel)
         REG_DIGIT_COUNT: begin
            csr_prdata = DATA_W'(cfg_ff.digit_count);
            if (wr_en) begin
               cfg_in.digit_count = csr_pwdata[CNT_W-1:0];
            end
         end
         REG_COMMON_ANODE: begin
            csr_prdata = DATA_W'(cfg_ff.common_anode);
            if (wr_en) begin
               cfg_in.common_anode = csr_pwdata[0];
            end
         end
         REG_SCAN_BASE: begin
            csr_prdata = DATA_W'(cfg_ff.scan_base_ms);
            if (wr_en) begin
               cfg_in.scan_base_ms = csr_pwdata[BASE_W-1:0];
            end
         end
         default: begin
            csr_prdata = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.digit_count  <= DIGIT_COUNT_RST;
         cfg_ff.common_anode <= COMMON_ANODE_RST;
         cfg_ff.scan_base_ms <= SCAN_BASE_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ----- rtl/mss_bcd.sv -----
module mss_bcd (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [mss_pkg::VALUE_W-1:0]   value,
   output logic                          done,
   output logic [mss_pkg::BCD_W-1:0]     bcd
);
   import mss_pkg::*;

   logic [VALUE_W-1:0] bin_ff, bin_in;
   logic [BCD_W-1:0]   bcd_ff, bcd_in;
   logic [BCD_W-1:0]   adj;
   logic [STEP_W-1:0]  step_ff, step_in;
   logic               run_ff, run_in;
   logic               done_ff, done_in;

   assign done = done_ff;
   assign bcd  = bcd_ff;

   // One shift-and-add-3 step per cycle.
   always_comb begin
      for (int n = 0; n < BCD_W / 4; n++) begin
         adj[n*4 +: 4] = (bcd_ff[n*4 +: 4] >= 4'd5) ? bcd_ff[n*4 +: 4] + 4'd3
                                                    : bcd_ff[n*4 +: 4];
      end
   end

   always_comb begin
      bin_in  = bin_ff;
      bcd_in  = bcd_ff;
      step_in = step_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      if (start) begin
         bin_in  = value;
         bcd_in  = '0;
         step_in = '0;
         run_in  = 1'b1;
      end else if (run_ff) begin
         bcd_in  = {adj[BCD_W-2:0], bin_ff[VALUE_W-1]};
         bin_in  = {bin_ff[VALUE_W-2:0], 1'b0};
         step_in = step_ff + STEP_W'(1);
         if (step_ff == STEP_W'(BCD_STEPS - 1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      bin_ff <= bin_in;
      bcd_ff <= bcd_in;
   end

endmodule

// ----- rtl/multiplexed_seven_segment_scanner_top.sv -----
// A request that lights a digit passes these steps: the elapsed-time subtract runs at
// acceptance, then the threshold compare, 14 double dabble steps in the BCD unit, a state
// that sees the finish, and one that forms the response. A new request is taken only once
// the previous one is through, which for an update includes the conversion and any wait
// for an earlier response to be claimed. Reset is synchronous and active high: it restores
// digit_count 4, common_anode 0, scan_base_ms 10, clears last update time and scan index.
module multiplexed_seven_segment_scanner_top (
   input  logic                        clock,
   input  logic                        reset,
   // Request channel.
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic [47:0]                 req_tdata,  // time_ms[31:0], value[45:32], zero fill
   // Response channel.
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [15:0]                 rsp_tdata,  // segments[7:0], digit_enables[11:8],
                                                   // digit_index[13:12], zero fill
   // Configuration port.
   input  logic                        csr_psel,
   input  logic                        csr_penable,
   input  logic                        csr_pwrite,
   input  logic [mss_pkg::ADDR_W-1:0]  csr_paddr,
   input  logic [mss_pkg::DATA_W-1:0]  csr_pwdata,
   output logic [mss_pkg::DATA_W-1:0]  csr_prdata,
   output logic                        csr_pready
);
   import mss_pkg::*;

   cfg_type   cfg;
   state_type state_ff, state_in;

   logic [TIME_W-1:0]  time_ff, time_in;
   logic [VALUE_W-1:0] value_ff, value_in;
   logic [TIME_W-1:0]  elapsed_ff, elapsed_in;
   logic [TIME_W-1:0]  last_update_ff, last_update_in;
   logic [IDX_W-1:0]   scan_ff, scan_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [15:0]        rsp_data_ff, rsp_data_in;

   logic [TIME_W-1:0]  req_time;
   logic [VALUE_W-1:0] req_value;
   logic [CNT_W-1:0]   count;
   logic [TIME_W+CNT_W-1:0] scaled;
   logic               fire;
   logic               bcd_start;
   logic               bcd_done;
   logic [BCD_W-1:0]   bcd;
   logic [IDX_W-1:0]   idx;
   logic [CNT_W-1:0]   idx_next;
   logic [SEG_W-1:0]   pattern;
   logic [3:0]         enables;
   logic               out_free;

   assign req_time  = req_tdata[TIME_W-1:0];
   assign req_value = req_tdata[TIME_W +: VALUE_W];

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   mss_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   mss_bcd u_bcd (
      .clock (clock),
      .reset (reset),
      .start (bcd_start),
      .value (value_ff),
      .done  (bcd_done),
      .bcd   (bcd)
   );

   // The per-digit threshold is floor(scan_base_ms / count). For integers,
   // elapsed > floor(base / count) holds exactly when elapsed * count > base,
   // so the compare needs no divider.
   assign count  = eff_count(cfg.digit_count);
   assign scaled = (TIME_W+CNT_W)'(elapsed_ff) * (TIME_W+CNT_W)'(count);
   assign fire   = scaled > (TIME_W+CNT_W)'(cfg.scan_base_ms);

   // A scan index left beyond a lowered digit count restarts at the units digit.
   always_comb begin
      idx = scan_ff;
      if (CNT_W'(scan_ff) >= count) begin
         idx = '0;
      end
      idx_next = CNT_W'(idx) + CNT_W'(1);
   end

   always_comb begin
      pattern = seg_pattern(bcd[idx*4 +: 4]);
      if (cfg.common_anode) begin
         pattern = ~pattern;
      end
      enables = ~(4'b0001 << idx);
   end

   always_comb begin
      state_in       = state_ff;
      time_in        = time_ff;
      value_in       = value_ff;
      elapsed_in     = elapsed_ff;
      last_update_in = last_update_ff;
      scan_in        = scan_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_data_in    = rsp_data_ff;
      bcd_start      = 1'b0;

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               time_in    = req_time;
               value_in   = (req_value > VALUE_MAX) ? VALUE_MAX : req_value;
               elapsed_in = req_time - last_update_ff;
               state_in   = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (fire) begin
               bcd_start = 1'b1;
               state_in  = ST_CONV;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_CONV: begin
            if (bcd_done) begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            // Wait here while an earlier response is still unclaimed.
            if (out_free) begin
               rsp_valid_in   = 1'b1;
               rsp_data_in    = {2'b00, idx, enables, pattern};
               last_update_in = time_ff;
               scan_in        = (idx_next >= count) ? '0 : idx_next[IDX_W-1:0];
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         last_update_ff <= '0;
         scan_ff        <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         last_update_ff <= last_update_in;
         scan_ff        <= scan_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      time_ff     <= time_in;
      value_ff    <= value_in;
      elapsed_ff  <= elapsed_in;
      rsp_data_ff <= rsp_data_in;
   end

`ifndef ASSERT_OFF
   a_done_in_conv: assert property (@(posedge clock) disable iff (reset)
      bcd_done |-> state_ff == ST_CONV)
      else $error("BCD unit finished outside the conversion state");

   a_bcd_digits: assert property (@(posedge clock) disable iff (reset)
      bcd_done |-> (bcd[3:0] <= 4'd9) && (bcd[7:4] <= 4'd9)
                   && (bcd[11:8] <= 4'd9) && (bcd[15:12] <= 4'd9))
      else $error("BCD conversion produced a digit above nine");

   a_one_enable_low: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> $countones(rsp_data_ff[11:8]) == 3)
      else $error("response does not pull exactly one digit enable low");

   a_update_time: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_OUT && out_free) |=> rsp_valid_ff && last_update_ff == $past(time_ff))
      else $error("digit update did not record its time");
`endif

endmodule

// ----- tb/sv/scan_checker.sv -----
`timescale 1ns / 100ps

module scan_checker (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   input  logic                       req_tready,
   input  logic [47:0]                req_tdata,   // time_ms[31:0], value[45:32], zero fill
   input  logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   input  logic [15:0]                rsp_tdata,   // segments[7:0], digit_enables[11:8],
                                                   // digit_index[13:12], zero fill
   input  logic                       csr_psel,
   input  logic                       csr_penable,
   input  logic                       csr_pwrite,
   input  logic                       csr_pready,
   input  logic [mss_pkg::ADDR_W-1:0] csr_paddr,
   input  logic [mss_pkg::DATA_W-1:0] csr_pwdata,
   output int unsigned                fail_count,
   output int unsigned                pending_drives
);

   typedef struct packed {
      logic [7:0] segments;
      logic [3:0] digit_enables;
      logic [1:0] digit_index;
   } digit_drive_type;

   // Glyphs for 0..9, digit n in bits [8n+7:8n]; segment a is bit 0.
   localparam logic [79:0] GLYPHS = {8'h67, 8'h7F, 8'h07, 8'h7D, 8'h6D,
                                     8'h66, 8'h4F, 8'h5B, 8'h06, 8'h3F};
   localparam int unsigned REPORT_LIMIT = 10;

   digit_drive_type expected_drives[$];
   logic [2:0]   digit_count_r;
   logic         anode_r;
   logic [7:0]   scan_base_r;
   logic [31:0]  last_lit_ms;
   logic [1:0]   next_digit;
   int unsigned  failures;

   initial begin
      failures = 0;
   end

   function automatic void note_failure(input string what);
      failures++;
      if (failures <= REPORT_LIMIT) begin
         $display("[%0t] scan mismatch: %s", $realtime, what);
      end
   endfunction

   // Works out whether this tick lights a digit and, if so, queues the drive.
   function automatic void predict_tick(input logic [31:0] now, input logic [13:0] value);
      int unsigned  lit_count;
      int unsigned  threshold;
      int unsigned  shown;
      int unsigned  place;
      int unsigned  idx;
      logic [31:0]  elapsed;
      logic [3:0]   bcd;
      digit_drive_type drive;
      lit_count = (digit_count_r == 3'd0) ? 1 :
                  (digit_count_r > mss_pkg::MAX_DIGITS) ? mss_pkg::MAX_DIGITS :
                  int'(digit_count_r);
      threshold = int'(scan_base_r) / lit_count;
      elapsed   = now - last_lit_ms;
      if (elapsed <= threshold) begin
         return;
      end
      shown = (value > 14'd9999) ? 9999 : int'(value);
      idx   = int'(next_digit);
      if (idx >= lit_count) begin
         idx = 0;
      end
      place = 1;
      repeat (idx) place = place * 10;
      bcd = 4'((shown / place) % 10);
      drive.segments      = GLYPHS[bcd*8 +: 8];
      if (anode_r) begin
         drive.segments = ~drive.segments;
      end
      drive.digit_enables = 4'hF & ~(4'b0001 << idx);
      drive.digit_index   = 2'(idx);
      expected_drives.push_back(drive);
      last_lit_ms = now;
      next_digit  = (idx + 1 >= lit_count) ? 2'd0 : 2'(idx + 1);
   endfunction

   always @(posedge clock) begin
      digit_drive_type got;
      digit_drive_type want;
      if (reset) begin
         digit_count_r = mss_pkg::DIGIT_COUNT_RST;
         anode_r       = mss_pkg::COMMON_ANODE_RST;
         scan_base_r   = mss_pkg::SCAN_BASE_RST;
         last_lit_ms   = '0;
         next_digit    = '0;
         expected_drives.delete();
      end else begin
         // Responses are matched first: anything leaving now came from an older request.
         if (rsp_tvalid && rsp_tready) begin
            got.segments      = rsp_tdata[7:0];
            got.digit_enables = rsp_tdata[11:8];
            got.digit_index   = rsp_tdata[13:12];
            if (expected_drives.size() == 0) begin
               note_failure($sformatf("unexpected response seg=%h en=%h idx=%0d",
                                      got.segments, got.digit_enables, got.digit_index));
            end else begin
               want = expected_drives.pop_front();
               if (got.segments != want.segments) begin
                  note_failure($sformatf("segments expected %h got %h",
                                         want.segments, got.segments));
               end
               if (got.digit_enables != want.digit_enables) begin
                  note_failure($sformatf("digit_enables expected %h got %h",
                                         want.digit_enables, got.digit_enables));
               end
               if (got.digit_index != want.digit_index) begin
                  note_failure($sformatf("digit_index expected %0d got %0d",
                                         want.digit_index, got.digit_index));
               end
            end
         end
         if (req_tvalid && req_tready) begin
            predict_tick(req_tdata[31:0], req_tdata[45:32]);
         end
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (mss_pkg::reg_index_type'(csr_paddr[3:2]))
               mss_pkg::REG_DIGIT_COUNT: begin
                  digit_count_r = csr_pwdata[2:0];
               end
               mss_pkg::REG_COMMON_ANODE: begin
                  anode_r = csr_pwdata[0];
               end
               mss_pkg::REG_SCAN_BASE: begin
                  scan_base_r = csr_pwdata[7:0];
               end
               default: begin
               end
            endcase
         end
      end
      fail_count     <= failures;
      pending_drives <= expected_drives.size();
   end

endmodule

// ----- tb/sv/tb.sv -----
`timescale 1ns / 100ps

// Stimulus and verdict for the seven-segment scanner. Prediction and comparison
// live in scan_checker, which watches the same wires as the block.
module tb;

   import mss_pkg::*;

   // Quiet time allowed after the last expected response before touching the
   // registers or ending, so that a tick still in the block can finish.
   localparam int unsigned SETTLE_CYCLES   = 24;
   // Cycles without any accepted request or response before the run is abandoned.
   localparam int unsigned WATCHDOG_CYCLES = 3000;
   // Length of the one deliberate response back-pressure stretch.
   localparam int unsigned HOLD_CYCLES     = 400;
   localparam int unsigned PHASES          = 12;
   localparam int unsigned PHASE_TICKS     = 161;

   logic                clock       = 1'b0;
   logic                reset       = 1'b1;
   logic                req_tvalid  = 1'b0;
   logic                req_tready;
   logic [47:0]         req_tdata   = '0;
   logic                rsp_tvalid;
   logic                rsp_tready  = 1'b0;
   logic [15:0]         rsp_tdata;
   logic                csr_psel    = 1'b0;
   logic                csr_penable = 1'b0;
   logic                csr_pwrite  = 1'b0;
   logic [ADDR_W-1:0]   csr_paddr   = '0;
   logic [DATA_W-1:0]   csr_pwdata  = '0;
   logic [DATA_W-1:0]   csr_prdata;
   logic                csr_pready;

   int unsigned         fail_count;
   int unsigned         pending_drives;

   // Knobs shared between the request driver and the response sink.
   bit                  gaps_on     = 1'b1;
   bit                  stalls_on   = 1'b1;
   bit                  hold_wanted = 1'b0;
   bit                  hold_taken  = 1'b0;

   int unsigned         ticks_sent     = 0;
   int unsigned         responses_seen = 0;
   int unsigned         settings_used  = 0;
   int unsigned         idle_cycles    = 0;

   // Running millisecond time and the update threshold of the current
   // settings; both only shape the stimulus, the checker keeps its own view.
   logic [31:0]         stim_now       = '0;
   int unsigned         stim_threshold = 2;

   multiplexed_seven_segment_scanner_top i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   scan_checker i_checker (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .csr_psel       (csr_psel),
      .csr_penable    (csr_penable),
      .csr_pwrite     (csr_pwrite),
      .csr_pready     (csr_pready),
      .csr_paddr      (csr_paddr),
      .csr_pwdata     (csr_pwdata),
      .fail_count     (fail_count),
      .pending_drives (pending_drives)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // Response sink. It normally accepts every cycle, drops tready for short
   // random bursts while stalls are enabled, and once, on request from the
   // stimulus, holds off for a long stretch so the block backs up and stops
   // taking requests.
   initial begin
      forever begin
         @(posedge clock);
         if (hold_wanted && !hold_taken) begin
            hold_taken = 1'b1;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            rsp_tready <= 1'b1;
         end else if (stalls_on && $urandom_range(0, 4) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clock);
            rsp_tready <= 1'b1;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // Watchdog: any accepted request or response counts as progress.
   always @(posedge clock) begin
      if (rsp_tvalid && rsp_tready) begin
         responses_seen <= responses_seen + 1;
      end
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || reset) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_CYCLES) begin
            $display("Watchdog expired after %0d quiet cycles", idle_cycles);
            $display("FAIL");
            $finish;
         end
      end
   end

   // Offers one tick and returns at the edge where it is accepted. With gaps
   // enabled, tvalid is sometimes dropped for a random burst first; otherwise
   // tvalid stays high straight into the next request.
   task automatic send_tick(input logic [31:0] now, input logic [13:0] value);
      if (gaps_on && $urandom_range(0, 4) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 7)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {2'b00, value, now};
      do @(posedge clock); while (!req_tready);
      ticks_sent++;
   endtask

   // Stops offering requests and waits until every predicted digit update has
   // come out, then lets the block finish any tick that lights nothing.
   task automatic drain_block();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_drives != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // One register write: setup cycle, then access cycle, then an idle phase with psel
   // low so back-to-back writes never reassign psel within one step.
   task automatic csr_write(input reg_index_type index, input logic [DATA_W-1:0] data);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= ADDR_W'({index, 2'b00});
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   // Reprograms all three registers while the block is quiet.
   task automatic apply_settings(input logic [2:0] count, input logic anode,
                                 input logic [7:0] base);
      int unsigned lit;
      drain_block();
      csr_write(REG_DIGIT_COUNT, DATA_W'(count));
      csr_write(REG_COMMON_ANODE, DATA_W'(anode));
      csr_write(REG_SCAN_BASE, DATA_W'(base));
      lit = (count == 3'd0) ? 1 : (count > MAX_DIGITS) ? MAX_DIGITS : int'(count);
      stim_threshold = int'(base) / lit;
      settings_used++;
   endtask

   // Random ticks around the current threshold. Most steps land near it so
   // roughly half the ticks light a digit; some repeat the same time, some
   // sit exactly on the boundary, and some jump anywhere in the 32-bit range
   // so the time wraps. A share of the values exceed 9999.
   task automatic random_ticks(input int unsigned count);
      int unsigned pick;
      logic [31:0] step;
      logic [13:0] value;
      for (int unsigned k = 0; k < count; k++) begin
         pick = $urandom_range(0, 99);
         if (pick < 70) begin
            step = $urandom_range(0, 2 * stim_threshold + 2);
         end else if (pick < 80) begin
            step = '0;
         end else if (pick < 90) begin
            step = stim_threshold + $urandom_range(0, 1);
         end else begin
            step = $urandom;
         end
         stim_now = stim_now + step;
         if ($urandom_range(0, 6) == 0) begin
            value = 14'($urandom);
         end else begin
            value = 14'($urandom_range(0, 9999));
         end
         send_tick(stim_now, value);
      end
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part under the reset settings: four digits, common cathode,
      // 10 ms period, so a digit is lit once more than 2 ms have passed.
      send_tick(32'd0, 14'd0);               // no time elapsed since reset
      send_tick(32'd2, 14'd1);               // elapsed equals the threshold: nothing
      send_tick(32'd3, 14'd0);               // units digit of zero
      send_tick(32'd6, 14'd9999);            // tens digit of the largest value
      send_tick(32'd9, 14'h3FFF);            // all value bits set, clipped to 9999
      send_tick(32'd12, 14'd1234);           // thousands digit, scan wraps to units
      send_tick(32'hFFFF_FFFF, 14'd5678);    // top of the time range
      send_tick(32'd1, 14'd4321);            // elapsed 2 across the time wrap: nothing
      send_tick(32'd2, 14'h2AAA);            // elapsed 3 across the wrap, value clipped
      send_tick(32'd5, 14'h1555);            // scan index now sits at the last digit

      // Two digits with the index still at 3: the scan restarts at units.
      // A zero period means any nonzero elapsed time lights a digit.
      apply_settings(3'd2, 1'b1, 8'd0);
      send_tick(32'd5, 14'd7890);            // same time again: nothing
      send_tick(32'd6, 14'd7890);
      send_tick(32'd7, 14'd6060);
      send_tick(32'd8, 14'd8080);

      // A digit count of zero behaves as one; longest period.
      apply_settings(3'd0, 1'b0, 8'd255);
      send_tick(32'd263, 14'd42);            // exactly 255 ms later: nothing
      send_tick(32'd264, 14'd42);
      send_tick(32'd519, 14'd9);

      // Counts above four are clamped.
      apply_settings(3'd7, 1'b1, 8'd1);
      send_tick(32'd520, 14'd3579);
      send_tick(32'd521, 14'd3579);
      send_tick(32'd522, 14'd3579);
      send_tick(32'd523, 14'd3579);
      stim_now = 32'd523;

      // Random part: each phase reprograms the registers, the first ones at
      // the extremes. Phase four also forces the long response hold-off while
      // requests keep coming, and the last phase runs with no idling at all.
      for (int unsigned p = 0; p < PHASES; p++) begin
         case (p)
            0: begin
               apply_settings(3'd1, 1'b1, 8'd255);
            end
            1: begin
               apply_settings(3'd7, 1'b0, 8'd0);
            end
            2: begin
               apply_settings(3'd4, 1'b1, 8'd1);
            end
            4: begin
               apply_settings(3'd4, 1'b0, 8'd3);
               hold_wanted = 1'b1;
            end
            default: begin
               apply_settings(3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)),
                              8'($urandom_range(0, 255)));
            end
         endcase
         if (p == PHASES - 1) begin
            gaps_on   = 1'b0;
            stalls_on = 1'b0;
         end
         random_ticks(PHASE_TICKS);
      end

      drain_block();
      $display("Sent %0d ticks, %0d digit updates came back, over %0d register settings.",
               ticks_sent, responses_seen, settings_used + 1);
      $display("Included clipped values, time wrap, index wrap, clamped counts, zero period.");
      if (fail_count == 0 && pending_drives == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
rtl/mss_pkg.sv
rtl/mss_csr.sv
rtl/mss_bcd.sv
rtl/multiplexed_seven_segment_scanner_top.sv
tb/sv/scan_checker.sv
tb/sv/tb.sv
